### rtl/alpha_blit_compositor_assert.svh
// Assertion macros for the alpha blit compositor.
// Included by modules that check their own logic; expects aclk and aresetn in scope.
`ifndef ALPHA_BLIT_COMPOSITOR_ASSERT_SVH
`define ALPHA_BLIT_COMPOSITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ABC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("alpha_blit_compositor: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ABC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("alpha_blit_compositor: next-cycle check failed");

`endif

### rtl/abc_pkg.sv
// Shared types, constants and the per-byte blend function of the alpha blit compositor.
// No dependencies; imported by alpha_blit_compositor, blit_write_checker and tb_alpha_blit_compositor.
`timescale 1ns / 1ps

package abc_pkg;

    localparam int PIXEL_W   = 32;
    localparam int ADDR_W    = 25;
    localparam int SIZE_W    = 13;   // dest_width, source_width, source_height
    localparam int OFFSET_W  = 12;   // offset_x, offset_y
    localparam int CFG_IDX_W = 3;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [OFFSET_W-1:0] offset_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_WIDTH    = 3'd0,
        CFG_SOURCE_WIDTH  = 3'd1,
        CFG_SOURCE_HEIGHT = 3'd2,
        CFG_OFFSET_X      = 3'd3,
        CFG_OFFSET_Y      = 3'd4,
        CFG_BLEND_MODE    = 3'd5
    } cfg_index_t;

    typedef enum logic {
        MODE_COPY  = 1'b0,
        MODE_BLEND = 1'b1
    } blend_mode_t;

    // Per byte: (s*a + d*(256-a)) >> 8, a taken from the source alpha byte.
    // The sum never exceeds 255*256, so the result byte needs no saturation.
    function automatic pixel_t blend_argb(input pixel_t s, input pixel_t d);
        logic [7:0]  a;
        logic [8:0]  inv_a;
        logic [16:0] acc;
        pixel_t      res;
        a     = s[31:24];
        inv_a = 9'd256 - {1'b0, a};
        res   = '0;
        for (int k = 0; k < 4; k++) begin
            acc = 17'(s[8*k +: 8] * a) + 17'(d[8*k +: 8] * inv_a);
            res[8*k +: 8] = acc[15:8];
        end
        return res;
    endfunction

endpackage

### rtl/alpha_blit_compositor.sv
// Alpha blit compositor: raster-order source rectangle write-out with copy or alpha blend.
// Depends on abc_pkg and alpha_blit_compositor_assert.svh.
`timescale 1ns / 1ps
`include "alpha_blit_compositor_assert.svh"

// Takes one source pixel and the matching destination pixel per transaction and returns
// the destination address (offset_y+row)*dest_width + offset_x + column, wrapped to 25
// bits, with the pixel to store there: the source pixel in copy mode, or each byte as
// (s*a + d*(256-a)) >> 8 in blend mode. The last pixel of the rectangle carries m_last,
// after which the column and row counters restart at the top-left corner. A width or
// height of 0 acts as 1, one above 2^MAX_DIM_BITS acts as 2^MAX_DIM_BITS; no clipping.
// Throughput is one pixel per clock while m_ready is high. An input register holds the
// pixels and counter position, and the address multiply and the four byte blends sit
// between it and the result register. Only m_ready low stalls the stream. Write the
// configuration registers only while no transaction is in flight.
module alpha_blit_compositor #(
    parameter int MAX_DIM_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  abc_pkg::cfg_index_t   cfg_index,
    input  abc_pkg::size_t        cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  abc_pkg::pixel_t       s_src_pixel,
    input  abc_pkg::pixel_t       s_dst_pixel,

    output logic                  m_valid,
    input  logic                  m_ready,
    output abc_pkg::addr_t        m_dest_address,
    output abc_pkg::pixel_t       m_out_pixel,
    output logic                  m_last
);
    import abc_pkg::*;

    localparam int CMP_W   = ((MAX_DIM_BITS > SIZE_W) ? MAX_DIM_BITS : SIZE_W) + 1;
    localparam int YSUM_W  = ((MAX_DIM_BITS > OFFSET_W) ? MAX_DIM_BITS : OFFSET_W) + 1;
    localparam int PROD_W  = YSUM_W + SIZE_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(1) << MAX_DIM_BITS;

    // Configuration registers
    size_t       dest_width_reg;
    size_t       source_width_reg;
    size_t       source_height_reg;
    offset_t     offset_x_reg;
    offset_t     offset_y_reg;
    blend_mode_t blend_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_width_reg    <= SIZE_W'(1);
            source_width_reg  <= SIZE_W'(1);
            source_height_reg <= SIZE_W'(1);
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            blend_mode_reg    <= MODE_COPY;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEST_WIDTH:    dest_width_reg    <= cfg_wdata;
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_wdata;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_wdata;
                CFG_OFFSET_X:      offset_x_reg      <= cfg_wdata[OFFSET_W-1:0];
                CFG_OFFSET_Y:      offset_y_reg      <= cfg_wdata[OFFSET_W-1:0];
                CFG_BLEND_MODE:    blend_mode_reg    <= blend_mode_t'(cfg_wdata[0]);
                default: ;
            endcase
        end
    end

    // Clamped rectangle size, minus one, for the end-of-row and end-of-rect compares
    logic [CMP_W-1:0] width_ext, height_ext;
    logic [CMP_W-1:0] width_clamp, height_clamp;
    logic [CMP_W-1:0] width_m1, height_m1;

    always_comb begin
        width_ext  = CMP_W'(source_width_reg);
        height_ext = CMP_W'(source_height_reg);
        if (width_ext == '0) begin
            width_clamp = CMP_W'(1);
        end else if (width_ext > DIM_LIMIT) begin
            width_clamp = DIM_LIMIT;
        end else begin
            width_clamp = width_ext;
        end
        if (height_ext == '0) begin
            height_clamp = CMP_W'(1);
        end else if (height_ext > DIM_LIMIT) begin
            height_clamp = DIM_LIMIT;
        end else begin
            height_clamp = height_ext;
        end
        width_m1  = width_clamp - CMP_W'(1);
        height_m1 = height_clamp - CMP_W'(1);
    end

    // Handshake and pipeline control
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg,  m_valid_next;
    logic s1_adv;
    logic s_fire;

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;

    // Raster counters
    logic [MAX_DIM_BITS-1:0] column_reg, column_next;
    logic [MAX_DIM_BITS-1:0] row_reg,    row_next;
    logic                    row_end;
    logic                    rect_end;

    assign row_end  = CMP_W'(column_reg) >= width_m1;
    assign rect_end = row_end && (CMP_W'(row_reg) >= height_m1);

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        if (s_fire) begin
            if (rect_end) begin
                column_next = '0;
                row_next    = '0;
            end else if (row_end) begin
                column_next = '0;
                row_next    = row_reg + 1'b1;
            end else begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // Input register stage
    pixel_t                  s1_src_reg;
    pixel_t                  s1_dst_reg;
    logic [MAX_DIM_BITS-1:0] s1_col_reg;
    logic [MAX_DIM_BITS-1:0] s1_row_reg;
    logic                    s1_last_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_src_reg  <= s_src_pixel;
            s1_dst_reg  <= s_dst_pixel;
            s1_col_reg  <= column_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= rect_end;
        end
    end

    // Address and pixel math between the two register stages
    logic [YSUM_W-1:0] y_sum;
    logic [PROD_W-1:0] row_base;
    logic [SUM_W-1:0]  addr_full;
    pixel_t            pix_result;

    always_comb begin
        y_sum      = YSUM_W'(offset_y_reg) + YSUM_W'(s1_row_reg);
        row_base   = PROD_W'(y_sum * dest_width_reg);
        addr_full  = SUM_W'(row_base) + SUM_W'(offset_x_reg) + SUM_W'(s1_col_reg);
        pix_result = (blend_mode_reg == MODE_BLEND) ? blend_argb(s1_src_reg, s1_dst_reg)
                                                    : s1_src_reg;
    end

    // Result register stage
    addr_t  m_dest_address_reg;
    pixel_t m_out_pixel_reg;
    logic   m_last_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_adv) begin
            m_dest_address_reg <= addr_full[ADDR_W-1:0];
            m_out_pixel_reg    <= pix_result;
            m_last_reg         <= s1_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dest_address = m_dest_address_reg;
    assign m_out_pixel    = m_out_pixel_reg;
    assign m_last         = m_last_reg;

    // Checks on the counters and the stage transfer
    `ABC_ASSERT_NEXT(a_rect_end_restart, s_fire && rect_end,
        column_reg == '0 && row_reg == '0)
    `ABC_ASSERT_NEXT(a_column_step, s_fire && !row_end,
        column_reg == $past(column_reg) + 1'b1)
    `ABC_ASSERT_NEXT(a_stage_moves_to_output, s1_valid_reg && s1_adv, m_valid_reg)
    `ABC_ASSERT_NEXT(a_copy_passes_source,
        s1_valid_reg && s1_adv && blend_mode_reg == MODE_COPY,
        m_out_pixel_reg == $past(s1_src_reg))

endmodule

### sim/blit_write_checker.sv
// Write-stream checker for the alpha blit compositor: predicts every frame write and compares.
// Depends on abc_pkg; instantiated beside the block by tb_alpha_blit_compositor.
`timescale 1ns / 1ps

module blit_write_checker
    import abc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  cfg_index_t  cfg_index,
    input  size_t       cfg_wdata,

    input  logic        s_valid,
    input  logic        s_ready,
    input  pixel_t      s_src_pixel,
    input  pixel_t      s_dst_pixel,

    input  logic        m_valid,
    input  logic        m_ready,
    input  addr_t       m_dest_address,
    input  pixel_t      m_out_pixel,
    input  logic        m_last,

    output int          fail_count,
    output int          pending
);

    localparam int DIM_BITS  = 12;
    localparam int DIM_MAX   = 1 << DIM_BITS;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        addr_t  address;
        pixel_t pixel;
        logic   last;
    } frame_write_t;

    frame_write_t        expected_writes[$];
    size_t               frame_stride;
    size_t               rect_width;
    size_t               rect_height;
    offset_t             origin_x;
    offset_t             origin_y;
    blend_mode_t         compose_mode;
    logic [DIM_BITS-1:0] cur_col;
    logic [DIM_BITS-1:0] cur_row;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Zero acts as one, anything past the counter range as the full range.
    function automatic int unsigned extent(size_t v);
        if (v == '0)
            return 1;
        if (v > size_t'(DIM_MAX))
            return DIM_MAX;
        return v;
    endfunction

    function automatic pixel_t over_blend(pixel_t src, pixel_t dst);
        int unsigned alpha;
        int unsigned mix;
        pixel_t      blended;
        alpha   = src[31:24];
        blended = '0;
        for (int k = 0; k < 4; k++) begin
            mix = src[8*k +: 8] * alpha + dst[8*k +: 8] * (256 - alpha);
            blended[8*k +: 8] = 8'(mix >> 8);
        end
        return blended;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t blit_write_checker: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin : track
        frame_write_t      next_write;
        frame_write_t      seen;
        longint unsigned   flat;
        logic              row_done;
        if (!aresetn) begin
            frame_stride = size_t'(1);
            rect_width   = size_t'(1);
            rect_height  = size_t'(1);
            origin_x     = '0;
            origin_y     = '0;
            compose_mode = MODE_COPY;
            cur_col      = '0;
            cur_row      = '0;
            expected_writes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DEST_WIDTH:    frame_stride = cfg_wdata;
                    CFG_SOURCE_WIDTH:  rect_width   = cfg_wdata;
                    CFG_SOURCE_HEIGHT: rect_height  = cfg_wdata;
                    CFG_OFFSET_X:      origin_x     = cfg_wdata[OFFSET_W-1:0];
                    CFG_OFFSET_Y:      origin_y     = cfg_wdata[OFFSET_W-1:0];
                    CFG_BLEND_MODE:    compose_mode = blend_mode_t'(cfg_wdata[0]);
                    default: ;
                endcase
            end

            // Queue the new transaction first so a result leaving in the same cycle still finds it.
            if (s_valid && s_ready) begin
                flat = (64'(origin_y) + 64'(cur_row)) * 64'(frame_stride)
                       + 64'(origin_x) + 64'(cur_col);
                next_write.address = flat[ADDR_W-1:0];
                next_write.pixel   = (compose_mode == MODE_BLEND) ?
                                     over_blend(s_src_pixel, s_dst_pixel) : s_src_pixel;
                row_done           = cur_col >= extent(rect_width) - 1;
                next_write.last    = row_done && (cur_row >= extent(rect_height) - 1);
                if (next_write.last) begin
                    cur_col = '0;
                    cur_row = '0;
                end else if (row_done) begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end else begin
                    cur_col = cur_col + 1'b1;
                end
                expected_writes.push_back(next_write);
            end

            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    report("write with nothing outstanding", m_dest_address, 0);
                end else begin
                    seen = expected_writes.pop_front();
                    if (m_dest_address !== seen.address)
                        report("dest_address", m_dest_address, seen.address);
                    if (m_out_pixel !== seen.pixel)
                        report("out_pixel", m_out_pixel, seen.pixel);
                    if (m_last !== seen.last)
                        report("last", m_last, seen.last);
                end
            end
        end
        pending <= expected_writes.size();
    end

endmodule

### sim/tb_alpha_blit_compositor.sv
// Top of the alpha blit compositor testbench: clock, reset, configuration and pixel stimulus.
// Depends on abc_pkg, alpha_blit_compositor and blit_write_checker.
`timescale 1ns / 1ps

module tb_alpha_blit_compositor;
    import abc_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int RANDOM_ITEMS = 850;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_BURSTY
    } rx_pattern_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    cfg_index_t  cfg_index;
    size_t       cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    pixel_t      s_src_pixel;
    pixel_t      s_dst_pixel;
    logic        m_valid;
    logic        m_ready;
    addr_t       m_dest_address;
    pixel_t      m_out_pixel;
    logic        m_last;

    int          fail_count;
    int          pending;
    int          burst_left;
    rx_pattern_t rx_pattern;
    int          rx_pattern_left;
    int          rx_stall_left;

    alpha_blit_compositor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_pixel    (s_src_pixel),
        .s_dst_pixel    (s_dst_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_address (m_dest_address),
        .m_out_pixel    (m_out_pixel),
        .m_last         (m_last)
    );

    blit_write_checker u_write_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_pixel    (s_src_pixel),
        .s_dst_pixel    (s_dst_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_address (m_dest_address),
        .m_out_pixel    (m_out_pixel),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: switch between open, random and long-stall patterns.
    always @(negedge aclk) begin
        if (rx_pattern_left == 0) begin
            rx_pattern      = rx_pattern_t'($urandom_range(RX_OPEN, RX_BURSTY));
            rx_pattern_left = $urandom_range(20, 200);
        end else begin
            rx_pattern_left--;
        end
        case (rx_pattern)
            RX_OPEN:   m_ready <= 1'b1;
            RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) != 0);
            RX_BURSTY: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_stall_left = $urandom_range(1, 20);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: m_ready <= 1'b1;
        endcase
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("tb_alpha_blit_compositor: FAIL");
        $finish;
    end

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= size_t'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic rest(int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Hold the sender until every queued write has come out, then let the pipe empty.
    task automatic settle();
        rest(1);
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic push_pixel(pixel_t src, pixel_t dst);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_src_pixel <= src;
        s_dst_pixel <= dst;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            rest(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    function automatic pixel_t random_argb();
        pixel_t p;
        p = $urandom();
        case ($urandom_range(0, 5))
            0:       p[31:24] = 8'h00;
            1:       p[31:24] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    // Mostly small rectangles; now and then zero, full-range or oversize.
    function automatic int unsigned pick_extent();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 4096;
            2:       return 8191;
            3:       return $urandom_range(4097, 8190);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_stride();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 4096;
            3:       return 8191;
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    function automatic int unsigned pick_offset();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned count;

        aclk            = 1'b0;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_DEST_WIDTH;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_src_pixel     = '0;
        s_dst_pixel     = '0;
        m_ready         = 1'b0;
        burst_left      = 1;
        rx_pattern      = RX_OPEN;
        rx_pattern_left = 0;
        rx_stall_left   = 0;
        random_sent     = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: every pixel is a one-pixel rectangle at address 0.
        push_pixel(32'h0000_0000, 32'h0000_0000);
        push_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Blend at the far corner; the second row wraps past the address range.
        settle();
        write_reg(CFG_DEST_WIDTH, 8191);
        write_reg(CFG_SOURCE_WIDTH, 3);
        write_reg(CFG_SOURCE_HEIGHT, 2);
        write_reg(CFG_OFFSET_X, 4095);
        write_reg(CFG_OFFSET_Y, 4095);
        write_reg(CFG_BLEND_MODE, MODE_BLEND);
        push_pixel(32'h00FF_FFFF, 32'h1234_5678);
        push_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        push_pixel(32'h80FF_00FF, 32'h00FF_00FF);
        push_pixel(32'hFF00_0000, 32'hFFFF_FFFF);
        push_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        push_pixel(32'h7F12_3456, 32'hAA55_AA55);

        // Zero sizes act as one; zero stride.
        settle();
        write_reg(CFG_DEST_WIDTH, 0);
        write_reg(CFG_SOURCE_WIDTH, 0);
        write_reg(CFG_SOURCE_HEIGHT, 0);
        write_reg(CFG_OFFSET_X, 0);
        write_reg(CFG_OFFSET_Y, 0);
        write_reg(CFG_BLEND_MODE, MODE_COPY);
        push_pixel(32'hAAAA_AAAA, 32'h5555_5555);
        push_pixel(32'h5555_5555, 32'hAAAA_AAAA);

        // Oversize rectangle, then shrink it mid-row so row and rectangle end at once.
        settle();
        write_reg(CFG_DEST_WIDTH, 4096);
        write_reg(CFG_SOURCE_WIDTH, 8191);
        write_reg(CFG_SOURCE_HEIGHT, 8191);
        write_reg(CFG_OFFSET_X, 1);
        write_reg(CFG_OFFSET_Y, 2);
        repeat (4) push_pixel(random_argb(), $urandom());
        settle();
        write_reg(CFG_SOURCE_WIDTH, 2);
        write_reg(CFG_SOURCE_HEIGHT, 1);
        repeat (3) push_pixel(random_argb(), $urandom());

        while (random_sent < RANDOM_ITEMS) begin
            settle();
            w = pick_extent();
            h = pick_extent();
            write_reg(CFG_DEST_WIDTH, pick_stride());
            write_reg(CFG_SOURCE_WIDTH, w);
            write_reg(CFG_SOURCE_HEIGHT, h);
            write_reg(CFG_OFFSET_X, pick_offset());
            write_reg(CFG_OFFSET_Y, pick_offset());
            write_reg(CFG_BLEND_MODE, $urandom_range(MODE_COPY, MODE_BLEND));
            w    = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
            h    = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
            area = w * h;
            // Whole rectangles plus up to two more pixels where they are small, a partial one otherwise.
            if (area <= 48)
                count = area * $urandom_range(1, 48 / area) + $urandom_range(0, 2);
            else
                count = $urandom_range(5, 40);
            repeat (count) begin
                if ($urandom_range(0, 59) == 0)
                    settle();
                push_pixel(random_argb(), $urandom());
                random_sent++;
            end
        end

        rest(1);
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);

        if (fail_count == 0)
            $display("tb_alpha_blit_compositor: PASS");
        else
            $display("tb_alpha_blit_compositor: FAIL");
        $finish;
    end

endmodule
